/* rtl/dna_kmer_extractor_defines.svh */
// ---------------------------------------------------------------------------
// dna_kmer_extractor_defines.svh
// Assertion macros shared by the k-mer extractor RTL.
// ---------------------------------------------------------------------------
`ifndef DNA_KMER_EXTRACTOR_DEFINES_SVH
`define DNA_KMER_EXTRACTOR_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication under reset.
`define DKE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dke assertion failed: same-cycle implication");
// Next-cycle implication under reset.
`define DKE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dke assertion failed: next-cycle implication");
`else
`define DKE_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define DKE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/dke_pkg.sv */
// ---------------------------------------------------------------------------
// dke_pkg
// Types, constants and the base decoder of the k-mer extractor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dke_pkg;

    localparam int POSITION_BITS_DEF = 32;
    localparam int KMER_BITS         = 64;
    localparam int POS_OUT_BITS      = 32;
    localparam int KSIZE_BITS        = 6;
    localparam logic [5:0] KMER_MAX   = 6'd32;
    localparam logic [5:0] KMER_RESET = 6'd16;

    // 2-bit base codes; bit 2 of a decoded code marks an unknown base
    localparam logic [2:0] CODE_A   = 3'd0;
    localparam logic [2:0] CODE_C   = 3'd1;
    localparam logic [2:0] CODE_G   = 3'd2;
    localparam logic [2:0] CODE_T   = 3'd3;
    localparam logic [2:0] CODE_UNK = 3'd4;

    localparam logic [7:0] CHAR_A_UP = 8'h41;
    localparam logic [7:0] CHAR_A_LO = 8'h61;
    localparam logic [7:0] CHAR_C_UP = 8'h43;
    localparam logic [7:0] CHAR_C_LO = 8'h63;
    localparam logic [7:0] CHAR_G_UP = 8'h47;
    localparam logic [7:0] CHAR_G_LO = 8'h67;
    localparam logic [7:0] CHAR_T_UP = 8'h54;
    localparam logic [7:0] CHAR_T_LO = 8'h74;

    typedef struct packed {
        logic [KMER_BITS-1:0]    fwd;
        logic [KMER_BITS-1:0]    rev;
        logic [POS_OUT_BITS-1:0] pos;
    } pair_t;

    function automatic logic [2:0] map_base(input logic [7:0] ch);
        logic [2:0] code;
        unique case (ch) inside
            CHAR_A_UP, CHAR_A_LO: code = CODE_A;
            CHAR_C_UP, CHAR_C_LO: code = CODE_C;
            CHAR_G_UP, CHAR_G_LO: code = CODE_G;
            CHAR_T_UP, CHAR_T_LO: code = CODE_T;
            default:              code = CODE_UNK;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

/* rtl/dke_kmer_core.sv */
// ---------------------------------------------------------------------------
// dke_kmer_core
// Rolling forward and reverse-complement k-mer state, count and position.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dke_kmer_core #(
    parameter int POSITION_BITS = dke_pkg::POSITION_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [5:0]                kmer_length,
    input  wire logic                      advance,
    input  wire logic [7:0]                base_char,
    input  wire logic                      sequence_start,
    output logic                           emit,
    output dke_pkg::pair_t                 pair
);

    localparam int PO = (POSITION_BITS < dke_pkg::POS_OUT_BITS)
                        ? POSITION_BITS : dke_pkg::POS_OUT_BITS;

    logic [dke_pkg::KMER_BITS-1:0] fwd_reg, fwd_next, fwd_base;
    logic [dke_pkg::KMER_BITS-1:0] rev_reg, rev_next, rev_base;
    logic [5:0]                    cnt_reg, cnt_next, cnt_base;
    logic [POSITION_BITS-1:0]      pos_reg, pos_next, pos_base;

    logic [5:0]                    k_eff;
    logic [6:0]                    two_k;
    logic [5:0]                    rev_shift;
    logic [dke_pkg::KMER_BITS-1:0] mask;
    logic [2:0]                    code;
    logic [1:0]                    comp;
    logic                          known;

    // Clamp k to 1..32
    always_comb
    begin
        if (kmer_length == 6'd0)
            k_eff = 6'd1;
        else if (kmer_length > dke_pkg::KMER_MAX)
            k_eff = dke_pkg::KMER_MAX;
        else
            k_eff = kmer_length;
        two_k     = {k_eff, 1'b0};
        rev_shift = {k_eff[4:0] - 5'd1, 1'b0};
        mask      = {dke_pkg::KMER_BITS{1'b1}} >> (7'd64 - two_k);
    end

    always_comb
    begin
        // start of sequence clears everything before the base is applied
        fwd_base = sequence_start ? '0 : fwd_reg;
        rev_base = sequence_start ? '0 : rev_reg;
        cnt_base = sequence_start ? '0 : cnt_reg;
        pos_base = sequence_start ? '0 : pos_reg;

        code  = dke_pkg::map_base(base_char);
        known = !code[2];
        comp  = ~code[1:0];

        if (known)
        begin
            fwd_next = ((fwd_base << 2) | dke_pkg::KMER_BITS'(code[1:0])) & mask;
            rev_next = (rev_base >> 2) | (dke_pkg::KMER_BITS'(comp) << rev_shift);
            cnt_next = (cnt_base < k_eff) ? cnt_base + 6'd1 : cnt_base;
        end
        else
        begin
            fwd_next = '0;
            rev_next = '0;
            cnt_next = '0;
        end

        emit = known && (cnt_next >= k_eff);

        if (!known)
            pos_next = pos_base + POSITION_BITS'(k_eff);
        else if (emit)
            pos_next = pos_base + POSITION_BITS'(1);
        else
            pos_next = pos_base;

        pair.fwd = fwd_next;
        pair.rev = rev_next;
        pair.pos = dke_pkg::POS_OUT_BITS'(pos_base[PO-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= '0;
            rev_reg <= '0;
            cnt_reg <= '0;
            pos_reg <= '0;
        end
        else if (advance)
        begin
            fwd_reg <= fwd_next;
            rev_reg <= rev_next;
            cnt_reg <= cnt_next;
            pos_reg <= pos_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/dke_pair_out.sv */
// ---------------------------------------------------------------------------
// dke_pair_out
// Result register that sends one forward/reverse pair as two beats.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "dna_kmer_extractor_defines.svh"

module dke_pair_out (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           load,
    input  wire dke_pkg::pair_t pair,
    output logic                can_take,
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    output logic [95:0]         m_axis_tdata,   // [63:0] kmer_value, [95:64] position
    output logic [0:0]          m_axis_tuser,   // [0] strand
    output logic                m_axis_tlast    // last_of_pair
);

    dke_pkg::pair_t pair_reg;
    logic           valid_reg, valid_next;
    logic           phase_reg, phase_next;   // 0 forward beat, 1 reverse beat
    logic           beat_done;

    assign beat_done = valid_reg && m_axis_tready;
    assign can_take  = !valid_reg || (m_axis_tready && phase_reg);

    always_comb
    begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        if (load)
        begin
            valid_next = 1'b1;
            phase_next = 1'b0;
        end
        else if (beat_done)
        begin
            if (phase_reg)
                valid_next = 1'b0;
            else
                phase_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            pair_reg <= pair;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {pair_reg.pos, phase_reg ? pair_reg.rev : pair_reg.fwd};
    assign m_axis_tuser  = phase_reg;
    assign m_axis_tlast  = phase_reg;

    `DKE_ASSERT_SAME(a_load_only_when_free, clk, rst_n, load, can_take)
    `DKE_ASSERT_NEXT(a_fwd_then_rev, clk, rst_n,
                     beat_done && !phase_reg, valid_reg && phase_reg)
    `DKE_ASSERT_NEXT(a_stall_holds_phase, clk, rst_n,
                     valid_reg && !m_axis_tready && !load,
                     valid_reg && (phase_reg == $past(phase_reg)))

endmodule

`default_nettype wire

/* rtl/dna_kmer_extractor.sv */
// ---------------------------------------------------------------------------
// dna_kmer_extractor
// Rolling 2-bit k-mer extractor with reverse complement, top level.
// ---------------------------------------------------------------------------
//  channel  | direction | payload
//  ---------+-----------+---------------------------------------------------
//  s_axis   | in        | tdata[7:0] base_char, tuser[0] sequence_start
//  m_axis   | out       | tdata[63:0] kmer_value, [95:64] position,
//           |           | tuser[0] strand, tlast last_of_pair
//  cfg      | in        | cfg_data[5:0] k-mer length (always ready)
//
//  A request is taken into the input register; once the result register can
//  take a pair, the core applies it to the k-mer state and, if it emits,
//  loads the pair into the result register, which offers the forward beat.
//  An emitting character holds the result register for a forward beat, then
//  a reverse beat; a character that emits nothing is not loaded, but still
//  waits while a pair is being sent.
//  Reset clears the k-mer state, count, position and sets the k-mer length 16.
//  A stall on m_axis holds the result register; the input register takes
//  at most one request behind it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "dna_kmer_extractor_defines.svh"

module dna_kmer_extractor #(
    parameter int POSITION_BITS = dke_pkg::POSITION_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] base_char
    input  wire logic [0:0]  s_axis_tuser,   // [0] sequence_start
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [95:0]      m_axis_tdata,   // [63:0] kmer_value, [95:64] position
    output logic [0:0]       m_axis_tuser,   // [0] strand
    output logic             m_axis_tlast,   // last_of_pair
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [5:0]  cfg_data        // [5:0] k-mer length
);

    logic [5:0]     kmer_length_reg;
    logic           in_valid_reg, in_valid_next;
    logic [7:0]     in_char_reg;
    logic           in_start_reg;
    logic           s_accept;
    logic           advance;
    logic           emit;
    logic           pair_can_take;
    dke_pkg::pair_t pair;

    // Configuration register: write whenever offered
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            kmer_length_reg <= dke_pkg::KMER_RESET;
        else if (cfg_valid)
            kmer_length_reg <= cfg_data;
    end

    // Input register: advance the held request into the core when the
    // result register can take its pair, and refill in the same cycle
    assign advance       = in_valid_reg && pair_can_take;
    assign s_axis_tready = !in_valid_reg || pair_can_take;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_char_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser[0];
        end
    end

    dke_kmer_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .kmer_length    (kmer_length_reg),
        .advance        (advance),
        .base_char      (in_char_reg),
        .sequence_start (in_start_reg),
        .emit           (emit),
        .pair           (pair)
    );

    // Load the pair only for a character that emits; drop the rest
    dke_pair_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance && emit),
        .pair          (pair),
        .can_take      (pair_can_take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    `DKE_ASSERT_SAME(a_no_overwrite, clk, rst_n, s_accept && in_valid_reg, advance)
    `DKE_ASSERT_NEXT(a_held_when_blocked, clk, rst_n,
                     in_valid_reg && !pair_can_take,
                     in_valid_reg && $stable(in_char_reg))

endmodule

`default_nettype wire

/* test/dna_kmer_extractor_checker.sv */
// ---------------------------------------------------------------------------
// dna_kmer_extractor_checker
// Watches the request, result and configuration channels of the k-mer
// extractor. Predicts the forward/reverse pair each base causes and compares
// every result beat against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dna_kmer_extractor_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] base_char
    input  logic [0:0]  s_axis_tuser,   // [0] sequence_start
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [95:0] m_axis_tdata,   // [63:0] kmer_value, [95:64] position
    input  logic [0:0]  m_axis_tuser,   // [0] strand
    input  logic        m_axis_tlast,   // last_of_pair
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [5:0]  cfg_data,       // [5:0] k-mer length
    output int          mismatches,
    output int          outstanding
);

    localparam logic STRAND_FWD = 1'b0;
    localparam logic STRAND_REV = 1'b1;

    typedef struct packed {
        logic [dke_pkg::KMER_BITS-1:0]    value;
        logic                             strand;
        logic [dke_pkg::POS_OUT_BITS-1:0] position;
        logic                             last;
    } kmer_beat_t;

    kmer_beat_t                            kmer_pairs_due[$];
    logic [dke_pkg::KSIZE_BITS-1:0]        size_reg;
    logic [dke_pkg::KMER_BITS-1:0]         fwd_kmer;
    logic [dke_pkg::KMER_BITS-1:0]         rev_kmer;
    logic [dke_pkg::KSIZE_BITS-1:0]        base_count;
    logic [dke_pkg::POSITION_BITS_DEF-1:0] kmer_pos;

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin : watch
        kmer_beat_t                    got;
        kmer_beat_t                    want;
        int                            k;
        logic [dke_pkg::KMER_BITS-1:0] mask;
        logic [2:0]                    code;
        if (!rst_n)
        begin
            size_reg   = dke_pkg::KMER_RESET;
            fwd_kmer   = '0;
            rev_kmer   = '0;
            base_count = '0;
            kmer_pos   = '0;
            kmer_pairs_due.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                size_reg = cfg_data;

            if (s_axis_tvalid && s_axis_tready)
            begin
                // zero behaves as one, anything past the maximum as the maximum
                k = size_reg;
                if (k == 0)
                    k = 1;
                else if (k > dke_pkg::KMER_MAX)
                    k = dke_pkg::KMER_MAX;
                mask = {dke_pkg::KMER_BITS{1'b1}} >> (dke_pkg::KMER_BITS - 2 * k);

                if (s_axis_tuser[0])
                begin
                    fwd_kmer   = '0;
                    rev_kmer   = '0;
                    base_count = '0;
                    kmer_pos   = '0;
                end

                case (s_axis_tdata)
                    dke_pkg::CHAR_A_UP, dke_pkg::CHAR_A_LO: code = dke_pkg::CODE_A;
                    dke_pkg::CHAR_C_UP, dke_pkg::CHAR_C_LO: code = dke_pkg::CODE_C;
                    dke_pkg::CHAR_G_UP, dke_pkg::CHAR_G_LO: code = dke_pkg::CODE_G;
                    dke_pkg::CHAR_T_UP, dke_pkg::CHAR_T_LO: code = dke_pkg::CODE_T;
                    default:                                code = dke_pkg::CODE_UNK;
                endcase

                if (code == dke_pkg::CODE_UNK)
                begin
                    // unknown base: drop the open k-mer, skip the position by k
                    fwd_kmer   = '0;
                    rev_kmer   = '0;
                    base_count = '0;
                    kmer_pos   = kmer_pos + k;
                end
                else
                begin
                    fwd_kmer = ((fwd_kmer << 2) | code[1:0]) & mask;
                    rev_kmer = (rev_kmer >> 2) | ({62'd0, ~code[1:0]} << (2 * (k - 1)));
                    if (base_count < k)
                        base_count = base_count + 1'b1;
                    if (base_count >= k)
                    begin
                        want = {fwd_kmer, STRAND_FWD,
                                kmer_pos[dke_pkg::POS_OUT_BITS-1:0], 1'b0};
                        kmer_pairs_due.insert(kmer_pairs_due.size(), want);
                        want = {rev_kmer, STRAND_REV,
                                kmer_pos[dke_pkg::POS_OUT_BITS-1:0], 1'b1};
                        kmer_pairs_due.insert(kmer_pairs_due.size(), want);
                        kmer_pos = kmer_pos + 1'b1;
                    end
                end
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata[63:0], m_axis_tuser[0], m_axis_tdata[95:64],
                       m_axis_tlast};
                if (kmer_pairs_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result: kmer %h strand %b pos %h last %b",
                                 got.value, got.strand, got.position, got.last);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = kmer_pairs_due.pop_front();
                    if (got !== want)
                    begin
                        if (mismatches < 10)
                            $display({"result mismatch: expected kmer %h strand %b pos %h",
                                      " last %b, got kmer %h strand %b pos %h last %b"},
                                     want.value, want.strand, want.position, want.last,
                                     got.value, got.strand, got.position, got.last);
                        mismatches <= mismatches + 1;
                    end
                end
            end

            outstanding <= kmer_pairs_due.size();
        end
    end

endmodule

/* test/dna_kmer_extractor_test.sv */
// ---------------------------------------------------------------------------
// dna_kmer_extractor_test
// Stimulus and verdict for the k-mer extractor. Sends DNA characters on the
// request stream under several k-mer sizes and idle patterns; the checker
// beside the block predicts and compares every result beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dna_kmer_extractor_test;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;   // [7:0] base_char
    logic [0:0]  s_axis_tuser  = 1'b0;   // [0] sequence_start
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;           // [63:0] kmer_value, [95:64] position
    logic [0:0]  m_axis_tuser;           // [0] strand
    logic        m_axis_tlast;           // last_of_pair
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [5:0]  cfg_data      = 6'd0;   // [5:0] k-mer length

    int mismatches;
    int outstanding;

    // percent chance of an idle cycle on each side, changed per phase
    int send_idle = 6;
    int recv_idle = 46;

    dna_kmer_extractor uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    dna_kmer_extractor_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: throttle the result stream at the current idle rate.
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Hold a request until the block takes it; idle beforehand at random.
    // Leave tvalid high on return so back-to-back requests never drop it.
    task automatic push_char(input logic [7:0] ch, input logic start);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tuser  <= start;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Stop sending and hold off until every predicted beat has come out.
    // The checker's count is registered, so wait for a clock edge before reading it.
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Write the k-mer length only with the block idle: drain the results,
    // then give characters that emit nothing time to leave the pipeline.
    task automatic program_kmer_length(input logic [5:0] size);
        wait_results_drained();
        repeat (10) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= size;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Generous upper bound on the run; a hang ends here.
    initial
    begin
        #5000000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        string      opening;
        logic [5:0] size;
        logic [7:0] ch;
        int         unk_pct;
        int         r;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part at the reset size of 16: all eight letters, the first
        // request opening a sequence, so the first pair comes on the 16th base.
        opening = "ACGTacgtACGTACGTG";
        for (int i = 0; i < opening.len(); i++)
            push_char(opening[i], (i == 0));

        // Unknown bases: an N and bytes at both ends of the range, none emit.
        push_char(8'h4E, 1'b0);
        push_char(8'h80, 1'b0);
        push_char(8'hFF, 1'b0);
        push_char(8'h00, 1'b0);

        // Open a short k-mer, then shrink k under it: the next base emits at once.
        push_char("A", 1'b0);
        push_char("C", 1'b0);
        push_char("G", 1'b0);
        program_kmer_length(6'd2);
        push_char("T", 1'b0);
        // A new sequence clears the count, so this single base emits nothing.
        push_char("C", 1'b1);

        // Random part: three idle phases, four k-mer lengths in each.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle = 6;
                    recv_idle = 46;
                end
                1:
                begin
                    send_idle = 46;
                    recv_idle = 6;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            for (int seg = 0; seg < 4; seg++)
            begin
                case (phase * 4 + seg)
                    0:  size = 6'd1;
                    1:  size = 6'd32;
                    2:  size = 6'd0;
                    3:  size = 6'd63;
                    4:  size = 6'd5;
                    5:  size = 6'd16;
                    6:  size = 6'd33;
                    7:  size = 6'd2;
                    8:  size = 6'd12;
                    9:  size = 6'($urandom_range(1, 32));
                    10: size = 6'd31;
                    default: size = 6'($urandom_range(63));
                endcase
                program_kmer_length(size);
                // keep long k-mers reachable by making unknown bases rare
                unk_pct = (size >= 16) ? 1 : 8;
                for (int i = 0; i < 137; i++)
                begin
                    r = $urandom_range(99);
                    if (r < unk_pct)
                        ch = $urandom_range(1) ? 8'h4E : 8'($urandom_range(255));
                    else
                    begin
                        case ($urandom_range(7))
                            0: ch = "A";
                            1: ch = "a";
                            2: ch = "C";
                            3: ch = "c";
                            4: ch = "G";
                            5: ch = "g";
                            6: ch = "T";
                            default: ch = "t";
                        endcase
                    end
                    push_char(ch, ($urandom_range(99) < 2));
                    if (i == 70)
                        wait_results_drained();
                end
            end
        end

        wait_results_drained();
        repeat (20) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/dke_pkg.sv
rtl/dke_kmer_core.sv
rtl/dke_pair_out.sv
rtl/dna_kmer_extractor.sv
test/dna_kmer_extractor_checker.sv
test/dna_kmer_extractor_test.sv
